[design/assert_macros.svh]
// Assertion macros used by the decoder top level.
// Active in simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define LBSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low
`define LBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define LBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[design/lbsd_pkg.sv]
// Shared types, constants and helpers for the LZSS byte stream decoder.
// No dependencies; imported by every decoder module except lbsd_hist_ram.
`default_nettype none
package lbsd_pkg;

  // History window: 2**WIN_AW bytes
  localparam int WIN_AW = 12;
  localparam int LEN_W  = 32;
  localparam int OFF_W  = 12;
  localparam int CNT_W  = 5;

  localparam logic [8:0]       FLAG_MARK   = 9'h100;
  localparam logic [8:0]       FLAG_EMPTY  = 9'd1;
  localparam logic [8:0]       FLAG_RESET  = 9'd2;
  localparam logic [CNT_W-1:0] MATCH_BIAS  = 5'd3;
  localparam logic [1:0]       HDR_LAST    = 2'd3;

  typedef enum logic [6:0] {
    ST_HDR     = 7'b0000001,
    ST_FLAG    = 7'b0000010,
    ST_TOKEN   = 7'b0000100,
    ST_MATCH2  = 7'b0001000,
    ST_COPY_RD = 7'b0010000,
    ST_COPY    = 7'b0100000,
    ST_DONE    = 7'b1000000
  } lbsd_state_t;

  // One decoded byte leaving the sequencer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       bad;
  } lbsd_emit_t;

  // History memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } lbsd_ram_req_t;

  typedef struct packed {
    logic copying;
    logic done;
  } lbsd_status_t;

  function automatic logic [7:0] rotr1(input logic [7:0] v);
    return {v[0], v[7:1]};
  endfunction

endpackage
`default_nettype wire

[design/lbsd_hist_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the decoder history window; no dependencies.
`default_nettype none
module lbsd_hist_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/lbsd_addr_unit.sv]
// Shared offset unit: subtracts the match offset from the byte count,
// flags bad offsets and forms the history read address. Uses lbsd_pkg.
`default_nettype none
module lbsd_addr_unit (
  input  wire logic [lbsd_pkg::LEN_W-1:0]  bw,
  input  wire logic [lbsd_pkg::OFF_W-1:0]  off,
  output logic      [lbsd_pkg::WIN_AW-1:0] raddr,
  output logic                             bad
);
  import lbsd_pkg::*;

  logic [LEN_W:0] diff;

  // Borrow out means the offset reaches before the first byte
  assign diff  = {1'b0, bw} - {{(LEN_W + 1 - OFF_W){1'b0}}, off};
  assign bad   = (off == '0) || diff[LEN_W];
  assign raddr = diff[WIN_AW-1:0];

endmodule
`default_nettype wire

[design/lbsd_seq.sv]
// Decoder sequencer: header, flag and token parsing, and the match copy loop
// driving the history RAM through the shared offset unit. Uses lbsd_pkg.
`default_nettype none
module lbsd_seq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [7:0]              in_tdata,
  input  wire logic                    out_free,
  input  wire logic [7:0]              ram_rdata,
  output lbsd_pkg::lbsd_ram_req_t      ram_req,
  output lbsd_pkg::lbsd_emit_t         emit,
  output lbsd_pkg::lbsd_status_t       status
);
  import lbsd_pkg::*;

  lbsd_state_t       state_r, state_nxt;
  logic [1:0]        hdr_idx_r, hdr_idx_nxt;
  logic [8:0]        flag_r, flag_nxt;
  logic [7:0]        b1_r, b1_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt;
  logic [LEN_W-1:0]  bw_r, bw_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              bad_r, bad_nxt;
  logic              fwd_r, fwd_nxt;
  logic [7:0]        fwd_data_r, fwd_data_nxt;

  logic              in_acc;
  logic [LEN_W-1:0]  bw_inc;
  logic [LEN_W-1:0]  bw_op;
  logic [LEN_W-1:0]  left;
  logic [CNT_W-1:0]  len;
  logic [7:0]        val;
  logic [8:0]        flag_shift;
  logic              advance;
  logic              adv_done;
  logic [WIN_AW-1:0] au_raddr;
  logic              au_bad;

  assign in_acc     = in_tvalid && in_tready;
  assign bw_inc     = bw_r + 1'b1;
  assign left       = total_r - bw_r;
  assign len        = {1'b0, b1_r[3:0]} + MATCH_BIAS;
  assign flag_shift = {1'b0, flag_r[8:1]};
  assign val        = bad_r ? 8'd0 : (fwd_r ? fwd_data_r : ram_rdata);

  // Offset of the byte whose read is issued this cycle
  assign bw_op = (state_r == ST_COPY) ? bw_inc : bw_r;

  lbsd_addr_unit u_addr (
    .bw    (bw_op),
    .off   (off_r),
    .raddr (au_raddr),
    .bad   (au_bad)
  );

  // Accept input only in parsing states and ST_DONE, with room in the output stage
  assign in_tready = ((state_r == ST_HDR) || (state_r == ST_FLAG) ||
                      (state_r == ST_TOKEN) || (state_r == ST_MATCH2) ||
                      (state_r == ST_DONE)) && out_free;

  assign status.copying = (state_r == ST_COPY_RD) || (state_r == ST_COPY);
  assign status.done    = (state_r == ST_DONE);

  // Next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    hdr_idx_nxt   = hdr_idx_r;
    flag_nxt      = flag_r;
    b1_nxt        = b1_r;
    total_nxt     = total_r;
    bw_nxt        = bw_r;
    cnt_nxt       = cnt_r;
    off_nxt       = off_r;
    bad_nxt       = bad_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    advance       = 1'b0;
    adv_done      = 1'b0;
    emit          = '0;
    ram_req       = '0;
    ram_req.waddr = bw_r[WIN_AW-1:0];
    ram_req.raddr = au_raddr;

    case (state_r)
      ST_HDR: begin
        if (in_acc) begin
          total_nxt = total_r | ({24'd0, in_tdata} << {hdr_idx_r, 3'b000});
          if (hdr_idx_r == HDR_LAST) begin
            advance  = 1'b1;
            adv_done = (total_nxt == '0);
          end else begin
            hdr_idx_nxt = hdr_idx_r + 1'b1;
          end
        end
      end
      ST_FLAG: begin
        if (in_acc) begin
          flag_nxt  = FLAG_MARK | {1'b0, in_tdata};
          state_nxt = ST_TOKEN;
        end
      end
      ST_TOKEN: begin
        if (in_acc) begin
          if (flag_r[0]) begin
            // Literal: store and send at once
            emit.valid    = 1'b1;
            emit.data     = rotr1(in_tdata);
            emit.last     = 1'b1;
            emit.done     = (bw_inc >= total_r);
            ram_req.we    = 1'b1;
            ram_req.wdata = in_tdata;
            bw_nxt        = bw_inc;
            advance       = 1'b1;
            adv_done      = emit.done;
          end else begin
            b1_nxt    = in_tdata;
            state_nxt = ST_MATCH2;
          end
        end
      end
      ST_MATCH2: begin
        if (in_acc) begin
          off_nxt   = {in_tdata, b1_r[7:4]};
          cnt_nxt   = ({{(LEN_W - CNT_W){1'b0}}, len} > left) ? left[CNT_W-1:0] : len;
          state_nxt = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        // Issue the read for the first match byte
        ram_req.re = 1'b1;
        bad_nxt    = au_bad;
        fwd_nxt    = 1'b0;
        state_nxt  = ST_COPY;
      end
      ST_COPY: begin
        if (out_free) begin
          emit.valid    = 1'b1;
          emit.data     = rotr1(val);
          emit.last     = (cnt_r == 5'd1);
          emit.done     = (bw_inc >= total_r);
          emit.bad      = bad_r;
          ram_req.we    = 1'b1;
          ram_req.wdata = val;
          bw_nxt        = bw_inc;
          cnt_nxt       = cnt_r - 1'b1;
          // Issue the next read; bypass when it hits the entry written now
          ram_req.re    = 1'b1;
          bad_nxt       = au_bad;
          fwd_nxt       = !au_bad && (au_raddr == bw_r[WIN_AW-1:0]);
          fwd_data_nxt  = val;
          if (cnt_r == 5'd1) begin
            advance  = 1'b1;
            adv_done = emit.done;
          end
        end
      end
      ST_DONE: begin
        // Drop everything until reset
      end
      default: begin
        state_nxt = ST_HDR;
      end
    endcase

    // Move to the next token or finish
    if (advance) begin
      if (adv_done) begin
        state_nxt = ST_DONE;
      end else begin
        flag_nxt  = flag_shift;
        state_nxt = (flag_shift == FLAG_EMPTY) ? ST_FLAG : ST_TOKEN;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_HDR;
      hdr_idx_r <= '0;
      flag_r    <= FLAG_RESET;
      total_r   <= '0;
      bw_r      <= '0;
      cnt_r     <= '0;
      bad_r     <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      flag_r    <= flag_nxt;
      total_r   <= total_nxt;
      bw_r      <= bw_nxt;
      cnt_r     <= cnt_nxt;
      bad_r     <= bad_nxt;
      fwd_r     <= fwd_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    b1_r       <= b1_nxt;
    off_r      <= off_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

endmodule
`default_nettype wire

[design/lzss_byte_stream_decoder.sv]
// Channel  | dir | tdata (low bit up) | tlast    | tuser (low bit up)
// in_      | in  | in_byte[7:0]       | -        | -
// out_     | out | out_byte[7:0]      | run_last | done_res, bad_offset
//
// A header, flag or first match byte is parsed as it is accepted. A literal
// is stored and sent as it is accepted and yields one byte. A match takes
// its second byte, sets up the history read in ST_COPY_RD, then emits its
// bytes (up to 18) from ST_COPY while input waits; the single history read
// port and shared offset unit pace this copy loop. Output stalls hold the
// copy loop. Synchronous active-low reset; the history needs no clearing
// pass. Depends on lbsd_pkg, lbsd_seq and lbsd_hist_ram.
`default_nettype none
module lzss_byte_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [7:0] out_byte
  output logic            out_tlast,
  output logic      [1:0] out_tuser   // [0] done_res, [1] bad_offset
);
  import lbsd_pkg::*;
  `include "assert_macros.svh"

  lbsd_ram_req_t ram_req;
  lbsd_emit_t    emit;
  lbsd_status_t  status;
  logic [7:0]    ram_rdata;
  logic          out_free;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_done_r;
  logic          out_bad_r;

  logic          bad_shown;
  logic          done_shown;
  logic          copy_last;

  assign out_free = !out_valid_r || out_tready;

  lbsd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_free  (out_free),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .emit      (emit),
    .status    (status)
  );

  lbsd_hist_ram #(
    .AW (WIN_AW),
    .DW (8)
  ) u_hist (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output stage: load a new byte or drop the one transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_byte_r <= emit.data;
      out_last_r <= emit.last;
      out_done_r <= emit.done;
      out_bad_r  <= emit.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_bad_r, out_done_r};

  // Conditions watched by the checks
  assign bad_shown  = out_valid_r && out_bad_r;
  assign done_shown = out_valid_r && out_done_r;
  assign copy_last  = emit.valid && emit.last && status.copying;

  // Checks
  `LBSD_ASSERT_IMPL(a_emit_room, clk, rst_n, emit.valid, out_free, "emit into full output stage")
  `LBSD_ASSERT_IMPL(a_bad_zero, clk, rst_n, bad_shown, out_byte_r == 8'd0, "bad byte not zero")
  `LBSD_ASSERT_IMPL(a_done_last, clk, rst_n, done_shown, out_last_r, "done byte not last")
  `LBSD_ASSERT_NEXT(a_copy_end, clk, rst_n, copy_last, !status.copying, "copy ran past last byte")

endmodule
`default_nettype wire

[tb/sv/lbsd_checker.sv]
// Stream checker for lzss_byte_stream_decoder: predicts decoded bytes from input transfers
// and compares them, field by field, with output transfers. Depends on lbsd_pkg.
module lbsd_stream_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        out_tlast,
  input  wire logic [1:0]  out_tuser,
  output int unsigned      errors,
  output int unsigned      pending,
  output int unsigned      checked,
  output int unsigned      copied,
  output int unsigned      flagged
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbsd_pkg::*;

  localparam int HIST_DEPTH = 1 << WIN_AW;

  typedef enum logic [2:0] {
    HDR_BYTE,
    WANT_FLAG,
    WANT_TOKEN,
    WANT_MATCH2,
    STREAM_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       bad;
  } decoded_byte_t;

  // Decoder state as seen from the stream
  parse_phase_t  phase = HDR_BYTE;
  int            hdr_idx = 0;
  logic [8:0]    flag_bits = FLAG_RESET;
  logic [7:0]    match_lo = '0;
  logic [31:0]   total_len = '0;
  logic [31:0]   written = '0;
  logic [7:0]    hist [HIST_DEPTH];
  decoded_byte_t decoded_q [$];

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    copied = 0;
    flagged = 0;
  end

  // Advance to the next token, or stop once the decoded length is reached
  task automatic next_token();
    if (written >= total_len) begin
      phase = STREAM_DONE;
    end else begin
      flag_bits = flag_bits >> 1;
      phase = (flag_bits == FLAG_EMPTY) ? WANT_FLAG : WANT_TOKEN;
    end
  endtask

  // Store one decoded byte in the history and queue its rotated form
  task automatic put_byte(input logic [7:0] v, input logic bad, input logic last);
    decoded_byte_t e;
    hist[written[WIN_AW-1:0]] = v;
    written = written + 1;
    e.data = {v[0], v[7:1]};
    e.last = last;
    e.done = (written >= total_len);
    e.bad  = bad;
    decoded_q.push_back(e);
  endtask

  // Consume one compressed byte
  task automatic decode_stream_byte(input logic [7:0] b);
    logic [11:0] off;
    logic [31:0] left;
    logic [31:0] src;
    int unsigned cnt;
    logic        bad;
    logic [7:0]  v;
    case (phase)
      HDR_BYTE: begin
        total_len[8*hdr_idx +: 8] = b;
        if (hdr_idx == 3) next_token();
        else hdr_idx++;
      end
      WANT_FLAG: begin
        flag_bits = FLAG_MARK | {1'b0, b};
        phase = WANT_TOKEN;
      end
      WANT_TOKEN: begin
        if (flag_bits[0]) begin
          put_byte(b, 1'b0, 1'b1);
          next_token();
        end else begin
          match_lo = b;
          phase = WANT_MATCH2;
        end
      end
      WANT_MATCH2: begin
        off = {b, match_lo[7:4]};
        cnt = match_lo[3:0] + MATCH_BIAS;
        left = total_len - written;
        if (cnt > left) cnt = left;
        for (int unsigned i = 0; i < cnt; i++) begin
          bad = (off == 0) || ({20'd0, off} > written);
          src = written - {20'd0, off};
          v = bad ? 8'h00 : hist[src[WIN_AW-1:0]];
          if (!bad) copied++;
          put_byte(v, bad, i == cnt - 1);
        end
        next_token();
      end
      default: ;
    endcase
  endtask

  task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] act_v);
    errors++;
    $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field,
             exp_v, act_v);
  endtask

  // Predict first, so a result can never race ahead of its expectation
  always @(posedge clk) begin
    decoded_byte_t e;
    if (!rst_n) begin
      phase = HDR_BYTE;
      hdr_idx = 0;
      flag_bits = FLAG_RESET;
      match_lo = '0;
      total_len = '0;
      written = '0;
      decoded_q.delete();
    end else begin
      if (in_tvalid && in_tready) decode_stream_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        checked++;
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected output transfer, expected none, %s 0x%02h %0b %02b",
                   $time, "actual data/last/user", out_tdata, out_tlast, out_tuser);
        end else begin
          e = decoded_q.pop_front();
          if (e.bad) flagged++;
          if (out_tdata != e.data) report("out_byte", e.data, out_tdata);
          if (out_tlast != e.last) report("run_last", {7'd0, e.last}, {7'd0, out_tlast});
          if (out_tuser[0] != e.done) report("done_res", {7'd0, e.done}, {7'd0, out_tuser[0]});
          if (out_tuser[1] != e.bad) report("bad_offset", {7'd0, e.bad}, {7'd0, out_tuser[1]});
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

[tb/sv/tb.sv]
// Top-level testbench for lzss_byte_stream_decoder: builds one compressed stream, drives it
// with bursty traffic and a stalling receiver, and reports the verdict.
// Uses lbsd_stream_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BUSY
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tready = 1'b0;
  wire logic       in_tready;
  wire logic       out_tvalid;
  wire logic [7:0] out_tdata;
  wire logic       out_tlast;
  wire logic [1:0] out_tuser;

  int unsigned errors, pending, checked, copied, flagged;

  // Stream under construction and the decoder progress it implies
  logic [7:0]  stream_q [$];
  int unsigned gen_total;
  int unsigned gen_written;
  logic [7:0]  flag_rest;
  int unsigned slots_left;

  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lzss_byte_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  lbsd_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .copied     (copied),
    .flagged    (flagged)
  );

  task automatic put_flag(input logic [7:0] f);
    stream_q.push_back(f);
    flag_rest = f;
    slots_left = 8;
  endtask

  task automatic put_literal(input logic [7:0] b);
    stream_q.push_back(b);
    if (gen_written < gen_total) gen_written++;
    flag_rest = flag_rest >> 1;
    slots_left--;
  endtask

  // Append a match token; the copy is clipped to the bytes still to come
  task automatic put_match(input logic [11:0] off, input logic [3:0] nib);
    int unsigned run_len;
    int unsigned left;
    stream_q.push_back({off[3:0], nib});
    stream_q.push_back(off[11:4]);
    run_len = nib + 3;
    left = gen_total - gen_written;
    gen_written += (run_len > left) ? left : run_len;
    flag_rest = flag_rest >> 1;
    slots_left--;
  endtask

  // Receiver: stretches of always-ready, coin-flip, sparse and mostly-busy acceptance
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_left[1:0] == 2'd0);
      default:   out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    int          roll;
    logic [11:0] off;
    logic [3:0]  nib;
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    int unsigned trail;

    // Header: decoded length, little-endian
    gen_total = $urandom_range(250, 330);
    gen_written = 0;
    slots_left = 0;
    flag_rest = '0;
    stream_q.push_back(gen_total[7:0]);
    stream_q.push_back(gen_total[15:8]);
    stream_q.push_back(gen_total[23:16]);
    stream_q.push_back(gen_total[31:24]);

    // Directed tokens: extreme literals, zero offset, far offset, run fill,
    // offset reaching the oldest byte, then one just past it
    put_flag(8'h93);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_match(12'h000, 4'h0);
    put_match(12'hFFF, 4'hF);
    put_literal(8'hA5);
    put_match(12'h001, 4'hF);
    put_match(gen_written[11:0], 4'h2);
    put_literal(8'h5A);
    put_flag(8'hFE);
    put_match(gen_written[11:0] + 12'd1, 4'h0);

    // Random tokens until the decoded length is reached
    while (gen_written < gen_total) begin
      if (slots_left == 0) put_flag(8'($urandom));
      if (flag_rest[0]) begin
        put_literal(8'($urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) off = 12'h000;
        else if (roll < 20) off = 12'($urandom_range(gen_written + 1, 4095));
        else off = 12'($urandom_range(1, gen_written));
        if (gen_total - gen_written < 18 && $urandom_range(0, 1) == 1) nib = 4'hF;
        else nib = 4'($urandom_range(0, 15));
        put_match(off, nib);
      end
    end

    // Bytes past the end of the stream must be swallowed without results
    trail = $urandom_range(2, 5);
    repeat (trail) stream_q.push_back(8'($urandom));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Send in bursts; a zero gap joins two bursts
    idx = 0;
    while (idx < stream_q.size()) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < stream_q.size(); k++) begin
        @(negedge clk);
        in_tvalid <= 1'b1;
        in_tdata <= stream_q[idx];
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then watch a while longer for stray results
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("Sent %0d stream bytes (%0d past the end); checked %0d decoded bytes.",
             stream_q.size(), trail, checked);
    $display("Decoded length %0d: %0d bytes copied from history, %0d flagged as bad offsets.",
             gen_total, copied, flagged);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/lbsd_pkg.sv
design/lbsd_hist_ram.sv
design/lbsd_addr_unit.sv
design/lbsd_seq.sv
design/lzss_byte_stream_decoder.sv
tb/sv/lbsd_checker.sv
tb/sv/tb.sv
